// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on the rising clock edge, with an active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    `ASSERT_PROP(lbl, clk, rst_n, !(expr), msg)

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== hw/rtl/dlts_pkg.sv =====
// ----------------------------------------------------------------------------
// dlts_pkg
// shared widths, command and status codes and the list entry type
// ----------------------------------------------------------------------------
`default_nettype none

package dlts_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_TICK_MS     = 10;

    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int TID_W  = 8;
    localparam int MS_W   = 32;
    localparam int DUE_W  = 8;
    localparam int CNT_W  = 5;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_cmd CMD_ADD      = 2'd0;
    localparam t_cmd CMD_TICK     = 2'd1;
    localparam t_cmd CMD_DISPATCH = 2'd2;

    localparam t_status ST_DONE = 2'd0;
    localparam t_status ST_FULL = 2'd1;
    localparam t_status ST_NONE = 2'd2;

    localparam logic [DUE_W-1:0] DUE_MAX = '1;

    typedef struct packed {
        logic [TID_W-1:0] task_id;
        logic [MS_W-1:0]  delta;
        logic [MS_W-1:0]  period;
        logic [DUE_W-1:0] due_count;
    } t_entry;

endpackage

`default_nettype wire

// ===== hw/rtl/dlts_if.sv =====
// ----------------------------------------------------------------------------
// dlts_if
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
`default_nettype none

interface dlts_in_if;
    import dlts_pkg::*;

    logic             valid;
    logic             ready;
    t_cmd             command;
    logic [TID_W-1:0] task_id;
    logic [MS_W-1:0]  delay_ms;
    logic [MS_W-1:0]  period_ms;

    modport source (output valid, command, task_id, delay_ms, period_ms, input ready);
    modport sink   (input valid, command, task_id, delay_ms, period_ms, output ready);
endinterface

interface dlts_out_if;
    import dlts_pkg::*;

    logic             valid;
    logic             ready;
    t_status          status;
    logic [TID_W-1:0] run_task;
    logic [CNT_W-1:0] task_count;

    modport source (output valid, status, run_task, task_count, input ready);
    modport sink   (input valid, status, run_task, task_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dlts_div.sv =====
// ----------------------------------------------------------------------------
// dlts_div
// two values divided by the tick length with one shared reciprocal multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module dlts_div #(
    parameter int TICK_MS = dlts_pkg::DEF_TICK_MS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [dlts_pkg::MS_W-1:0] i_a,
    input  wire logic [dlts_pkg::MS_W-1:0] i_b,
    output logic                           o_done,
    output logic [dlts_pkg::MS_W-1:0]      o_qa,
    output logic [dlts_pkg::MS_W-1:0]      o_qb
);
    import dlts_pkg::*;

    localparam int PW  = 2 * MS_W;
    localparam int L   = $clog2(TICK_MS);
    localparam int SH1 = (L > 0) ? 1 : 0;
    localparam int SH2 = (L > 0) ? L - 1 : 0;
    // reciprocal less its implicit top bit, the fix-up below adds it back
    localparam logic [PW-1:0] MAGIC_W =
        (((PW'(1) << MS_W) * ((PW'(1) << L) - PW'(TICK_MS))) / PW'(TICK_MS)) + PW'(1);
    localparam logic [MS_W-1:0] MAGIC     = MAGIC_W[MS_W-1:0];
    localparam logic [1:0]      LAST_STEP = 2'd2;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [1:0]           r_step, n_step;
    logic [1:0][MS_W-1:0] r_n, n_n;
    logic [1:0][MS_W-1:0] r_t, n_t;
    logic [1:0][MS_W-1:0] r_q, n_q;

    always_comb begin
        logic [PW-1:0]   prod;
        logic [MS_W-1:0] mul_in;
        logic [MS_W-1:0] diff;
        logic [MS_W:0]   acc;
        logic            lane;

        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_n    = r_n;
        n_t    = r_t;
        n_q    = r_q;
        // step 0 multiplies lane 0, step 1 lane 1 and finishes lane 0, step 2 finishes lane 1
        mul_in = r_n[r_step[0]];
        prod   = {{MS_W{1'b0}}, MAGIC} * {{MS_W{1'b0}}, mul_in};
        lane   = r_step[1];
        diff   = r_n[lane] - r_t[lane];
        acc    = {1'b0, r_t[lane]} + {1'b0, diff >> SH1};
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_n[0] = i_a;
            n_n[1] = i_b;
        end else if (r_busy) begin
            if (r_step != LAST_STEP)
                n_t[r_step[0]] = prod[PW-1:MS_W];
            if (r_step != 2'd0)
                n_q[lane] = acc[MS_W-1:0] >> SH2;
            n_step = r_step + 2'd1;
            if (r_step == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;
        r_t <= n_t;
        r_q <= n_q;
    end

    assign o_done = r_done;
    assign o_qa   = r_q[0];
    assign o_qb   = r_q[1];

endmodule

`default_nettype wire

// ===== hw/rtl/delta_list_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// delta_list_task_scheduler
// timer queue of tasks kept as a delta list in one entry memory
// ----------------------------------------------------------------------------
// The list lives in a single-port-write, registered-read memory used as a
// ring: removing the head only moves the head pointer, an insert walks the
// ring one entry per cycle and then moves the later entries up one slot per
// cycle, read and write overlapped. One command beat is taken at a time and
// its result beat is held in an output register, so the next command is taken
// while a result still waits. An add converts delay and period to ticks with
// a shared reciprocal multiplier, and a dispatch of a periodic task inserts
// it again. Entries beyond the count are never used, so the memory needs no
// clearing after reset.
`default_nettype none
`include "assert_macros.svh"

module delta_list_task_scheduler #(
    parameter int MAX_ENTRIES = dlts_pkg::DEF_MAX_ENTRIES,
    parameter int TICK_MS     = dlts_pkg::DEF_TICK_MS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dlts_in_if.sink     i_in,
    dlts_out_if.source  o_out
);
    import dlts_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_HEAD  = 7'b0000100,
        S_INS   = 7'b0001000,
        S_WALK  = 7'b0010000,
        S_SHIFT = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // ring index of the entry at a given list position
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW + 1)'(head) + (CW + 1)'(off);
        if (s >= (CW + 1)'(MAX_ENTRIES))
            s = s - (CW + 1)'(MAX_ENTRIES);
        return s[AW-1:0];
    endfunction

    t_state           r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_total, n_total;
    t_cmd             r_cmd, n_cmd;
    t_entry           r_ins, n_ins;
    logic [CW-1:0]    r_pos, n_pos;
    logic [MS_W-1:0]  r_before, n_before;
    logic [CW-1:0]    r_moves, n_moves;
    logic [CW-1:0]    r_src, n_src;
    logic [CW-1:0]    r_dest, n_dest;
    logic             r_pend, n_pend;
    t_status          r_res_status, n_res_status;
    logic [TID_W-1:0] r_res_run, n_res_run;
    logic             r_ov, n_ov;
    t_status          r_o_status, n_o_status;
    logic [TID_W-1:0] r_o_run, n_o_run;
    logic [CNT_W-1:0] r_o_count, n_o_count;

    t_entry           r_mem [MAX_ENTRIES];
    t_entry           r_rd;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    t_entry           wr_data;

    logic             in_fire;
    logic             div_start;
    logic             div_done;
    logic [MS_W-1:0]  div_qa;
    logic [MS_W-1:0]  div_qb;

    dlts_div #(
        .TICK_MS (TICK_MS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (i_in.delay_ms),
        .i_b     (i_in.period_ms),
        .o_done  (div_done),
        .o_qa    (div_qa),
        .o_qb    (div_qb)
    );

    assign in_fire = i_in.valid && i_in.ready;

    always_comb begin
        logic [MS_W:0] sum;
        t_entry        head;

        n_state      = r_state;
        n_head       = r_head;
        n_total      = r_total;
        n_cmd        = r_cmd;
        n_ins        = r_ins;
        n_pos        = r_pos;
        n_before     = r_before;
        n_moves      = r_moves;
        n_src        = r_src;
        n_dest       = r_dest;
        n_pend       = 1'b0;
        n_res_status = r_res_status;
        n_res_run    = r_res_run;
        rd_addr      = r_head;
        wr_en        = 1'b0;
        wr_addr      = r_head;
        wr_data      = r_ins;
        div_start    = 1'b0;
        head         = r_rd;
        sum          = {1'b0, r_before} + {1'b0, r_rd.delta};

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_cmd        = i_in.command;
                    n_ins        = '{task_id: i_in.task_id, delta: '0, period: '0,
                                     due_count: '0};
                    n_res_status = ST_NONE;
                    n_res_run    = '0;
                    n_state      = S_DONE;
                    unique case (i_in.command)
                        CMD_ADD: begin
                            if (r_total >= FULL_COUNT) begin
                                n_res_status = ST_FULL;
                            end else begin
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                        CMD_TICK, CMD_DISPATCH: begin
                            if (r_total != '0)
                                n_state = S_HEAD;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_ins.delta  = div_qa;
                    n_ins.period = div_qb;
                    n_res_status = ST_DONE;
                    n_state      = S_INS;
                end
            end
            S_HEAD: begin
                n_state = S_DONE;
                if (r_cmd == CMD_TICK) begin
                    if (head.delta == '0) begin
                        if (head.due_count != DUE_MAX)
                            head.due_count = head.due_count + DUE_W'(1);
                        if (head.period != '0)
                            head.delta = head.period;
                    end else begin
                        head.delta = head.delta - MS_W'(1);
                    end
                    wr_en        = 1'b1;
                    wr_addr      = r_head;
                    wr_data      = head;
                    n_res_status = ST_DONE;
                end else if (head.due_count != '0) begin
                    n_res_status = ST_DONE;
                    n_res_run    = head.task_id;
                    n_head       = phys(r_head, CW'(1));
                    n_total      = r_total - CW'(1);
                    if (head.period != '0) begin
                        n_ins           = head;
                        n_ins.due_count = head.due_count - DUE_W'(1);
                        n_state         = S_INS;
                    end
                end
            end
            S_INS: begin
                rd_addr  = r_head;
                n_pos    = '0;
                n_before = '0;
                n_state  = S_WALK;
            end
            S_WALK: begin
                // next position is fetched while the current one is compared
                rd_addr = phys(r_head, r_pos + CW'(1));
                if (r_pos == r_total) begin
                    wr_en         = 1'b1;
                    wr_addr       = phys(r_head, r_total);
                    wr_data       = r_ins;
                    wr_data.delta = r_ins.delta - r_before;
                    n_total       = r_total + CW'(1);
                    n_state       = S_DONE;
                end else if ({1'b0, r_ins.delta} > sum) begin
                    n_before = sum[MS_W-1:0];
                    n_pos    = r_pos + CW'(1);
                end else begin
                    n_ins.delta = r_ins.delta - r_before;
                    n_moves     = r_total - r_pos;
                    n_src       = r_total - CW'(1);
                    n_state     = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // read from the rear down, write one slot up in the following cycle
                if (r_moves != '0) begin
                    rd_addr = phys(r_head, r_src);
                    n_src   = r_src - CW'(1);
                    n_moves = r_moves - CW'(1);
                    n_dest  = r_src + CW'(1);
                    n_pend  = 1'b1;
                end
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = phys(r_head, r_dest);
                    wr_data = r_rd;
                    if (r_dest == r_pos + CW'(1))
                        wr_data.delta = r_rd.delta - r_ins.delta;
                end else if (r_moves == '0) begin
                    wr_en   = 1'b1;
                    wr_addr = phys(r_head, r_pos);
                    wr_data = r_ins;
                    n_total = r_total + CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || o_out.ready)
                    n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_ov       = r_ov && !o_out.ready;
        n_o_status = r_o_status;
        n_o_run    = r_o_run;
        n_o_count  = r_o_count;
        if (r_state == S_DONE && (!r_ov || o_out.ready)) begin
            n_ov       = 1'b1;
            n_o_status = r_res_status;
            n_o_run    = r_res_run;
            n_o_count  = CNT_W'(r_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_total <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_total <= n_total;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_ins        <= n_ins;
        r_pos        <= n_pos;
        r_before     <= n_before;
        r_moves      <= n_moves;
        r_src        <= n_src;
        r_dest       <= n_dest;
        r_res_status <= n_res_status;
        r_res_run    <= n_res_run;
        r_o_status   <= n_o_status;
        r_o_run      <= n_o_run;
        r_o_count    <= n_o_count;
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (wr_en)
            r_mem[wr_addr] <= wr_data;
        r_rd <= r_mem[rd_addr];
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_ov;
    assign o_out.status     = r_o_status;
    assign o_out.run_task   = r_o_run;
    assign o_out.task_count = r_o_count;

    `ASSERT_NEVER(a_total_max, i_clk, i_rst_n, r_total > FULL_COUNT, "entry count beyond capacity")
    `ASSERT_PROP(a_walk_pos, i_clk, i_rst_n, (r_state == S_WALK) |-> (r_pos <= r_total), "walk ran past the list end")
    `ASSERT_PROP(a_div_state, i_clk, i_rst_n, div_done |-> (r_state == S_DIV), "divider finished outside an add")

endmodule

`default_nettype wire
